### hw/rtl/versioned_lru_tag_cache_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the versioned LRU tag cache core
// Concurrent assertion wrappers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VERSIONED_LRU_TAG_CACHE_CORE_MACROS_SVH
`define VERSIONED_LRU_TAG_CACHE_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define VLTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define VLTC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define VLTC_ASSERT(lbl, prop, msg)
`define VLTC_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

### hw/rtl/vltc_pkg.sv
// ----------------------------------------------------------------------------
// Versioned LRU tag cache package
// Field widths, operation codes and the control bundle sent to every cell.
// ----------------------------------------------------------------------------
package vltc_pkg;

  localparam int unsigned MaxEntriesDefault = 16;
  localparam int unsigned KeyWidthDefault   = 32;

  localparam int unsigned OpW     = 2;
  localparam int unsigned KeyTagW = 32;
  localparam int unsigned VerW    = 48;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned CountW  = 5;

  typedef enum logic [OpW-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INVAL  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef struct packed {
    logic load;
    logic upd;
    logic lookup;
    logic inval;
  } cell_ctl_t;

endpackage

### hw/rtl/versioned_lru_tag_cache_core.sv
// ----------------------------------------------------------------------------
// Versioned LRU tag cache core
// Most-recently-used list of key/version entries kept in a row of cells.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i/in_ready_o   operation, key_tag, version
//   out      output     out_valid_o/out_ready_i hit, slot, stale_dropped,
//                                               evicted, removed, entry_count
//
// On the accept edge every cell registers its key and version compare; the
// list then shifts through the cell chain and the result register loads at
// the first edge at which that register is free. The result can wait in its
// register while the next beat is accepted; a beat waits in the cells until
// the result register is free. After reset the list is empty and holds the
// slot ids in ascending order.
// ----------------------------------------------------------------------------
`include "versioned_lru_tag_cache_core_macros.svh"

module versioned_lru_tag_cache_core #(
  parameter int unsigned MAX_ENTRIES = vltc_pkg::MaxEntriesDefault,
  parameter int unsigned KEY_WIDTH   = vltc_pkg::KeyWidthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [vltc_pkg::OpW-1:0]     operation_i,
  input  logic [vltc_pkg::KeyTagW-1:0] key_tag_i,
  input  logic [vltc_pkg::VerW-1:0]    version_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         hit_o,
  output logic [vltc_pkg::SlotW-1:0]   slot_o,
  output logic                         stale_dropped_o,
  output logic                         evicted_o,
  output logic                         removed_o,
  output logic [vltc_pkg::CountW-1:0]  entry_count_o
);

  localparam int unsigned IdW  = $clog2(MAX_ENTRIES);
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned KeyW = (KEY_WIDTH < vltc_pkg::KeyTagW) ? KEY_WIDTH
                                                                  : vltc_pkg::KeyTagW;
  localparam int unsigned VerW = vltc_pkg::VerW;

  logic                busy_q;
  vltc_pkg::op_e       op_q;
  logic [KeyW-1:0]     new_key_q;
  logic [VerW-1:0]     new_ver_q;
  logic [CntW-1:0]     vc_q, vc_d;

  logic                           out_valid_q;
  logic                           hit_q, hit_d;
  logic [vltc_pkg::SlotW-1:0]     slot_q, slot_d;
  logic                           stale_q, stale_d;
  logic                           evict_q, evict_d;
  logic                           removed_q, removed_d;
  logic [vltc_pkg::CountW-1:0]    count_q, count_d;

  logic                in_fire, out_free, done;
  logic                full, any_km, any_hit;
  logic [IdW-1:0]      front_id;
  vltc_pkg::cell_ctl_t ctl;

  logic [MAX_ENTRIES:0]   carry;
  logic [IdW-1:0]         ids     [MAX_ENTRIES];
  logic [KeyW-1:0]        keys    [MAX_ENTRIES];
  logic [VerW-1:0]        vers    [MAX_ENTRIES];
  logic [IdW-1:0]         sel_ids [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] km_vec, hit_vec;

  logic [vltc_pkg::SlotW+IdW-1:0]     slot_wide;
  logic [vltc_pkg::CountW+CntW-1:0]   count_wide;

  assign in_ready_o = ~busy_q;
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;
  assign done       = busy_q & out_free;

  always_comb begin
    ctl.load   = in_fire;
    ctl.upd    = done;
    ctl.lookup = 1'b0;
    ctl.inval  = 1'b0;
    case (op_q)
      vltc_pkg::OP_LOOKUP: ctl.lookup = busy_q;
      vltc_pkg::OP_INVAL:  ctl.inval  = busy_q;
      default:             ;
    endcase
  end

  assign carry[0] = 1'b0;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic [IdW-1:0]  prev_id,  next_id;
    logic [KeyW-1:0] prev_key, next_key;
    logic [VerW-1:0] prev_ver, next_ver;

    if (g == 0) begin : g_head
      assign prev_id  = front_id;
      assign prev_key = new_key_q;
      assign prev_ver = new_ver_q;
    end else begin : g_body
      assign prev_id  = ids[g-1];
      assign prev_key = keys[g-1];
      assign prev_ver = vers[g-1];
    end

    if (g == MAX_ENTRIES - 1) begin : g_tail
      assign next_id  = ids[g];
      assign next_key = keys[g];
      assign next_ver = vers[g];
    end else begin : g_mid
      assign next_id  = ids[g+1];
      assign next_key = keys[g+1];
      assign next_ver = vers[g+1];
    end

    vltc_cell #(
      .Index      (g),
      .NumEntries (MAX_ENTRIES),
      .IdW        (IdW),
      .KeyW       (KeyW),
      .CntW       (CntW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .vc_i        (vc_q),
      .cmp_key_i   (key_tag_i[KeyW-1:0]),
      .cmp_ver_i   (version_i),
      .carry_i     (carry[g]),
      .carry_o     (carry[g+1]),
      .prev_id_i   (prev_id),
      .prev_key_i  (prev_key),
      .prev_ver_i  (prev_ver),
      .next_id_i   (next_id),
      .next_key_i  (next_key),
      .next_ver_i  (next_ver),
      .front_id_i  (front_id),
      .sel_id_o    (sel_ids[g]),
      .id_o        (ids[g]),
      .key_o       (keys[g]),
      .ver_o       (vers[g]),
      .key_match_o (km_vec[g]),
      .hit_o       (hit_vec[g])
    );
  end

  always_comb begin
    front_id = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      front_id = front_id | sel_ids[i];
    end
  end

  assign full    = vc_q == CntW'(MAX_ENTRIES);
  assign any_km  = |km_vec;
  assign any_hit = |hit_vec;

  always_comb begin
    vc_d      = vc_q;
    hit_d     = 1'b0;
    stale_d   = 1'b0;
    evict_d   = 1'b0;
    removed_d = 1'b0;
    slot_wide = '0;
    case (op_q)
      vltc_pkg::OP_LOOKUP: begin
        hit_d     = any_hit;
        stale_d   = any_km & ~any_hit;
        evict_d   = ~any_km & full;
        slot_wide = {{vltc_pkg::SlotW{1'b0}}, front_id};
        if (!any_km && !full) begin
          vc_d = vc_q + CntW'(1);
        end
      end
      vltc_pkg::OP_INVAL: begin
        removed_d = any_km;
        if (any_km) begin
          vc_d = vc_q - CntW'(1);
        end
      end
      vltc_pkg::OP_CLEAR: begin
        vc_d = '0;
      end
      default: ;
    endcase
    slot_d     = slot_wide[vltc_pkg::SlotW-1:0];
    count_wide = {{vltc_pkg::CountW{1'b0}}, vc_d};
    count_d    = count_wide[vltc_pkg::CountW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      vc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        busy_q <= 1'b1;
      end else if (done) begin
        busy_q <= 1'b0;
      end
      if (done) begin
        vc_q <= vc_d;
      end
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q      <= vltc_pkg::op_e'(operation_i);
      new_key_q <= key_tag_i[KeyW-1:0];
      new_ver_q <= version_i;
    end
    if (done) begin
      hit_q     <= hit_d;
      slot_q    <= slot_d;
      stale_q   <= stale_d;
      evict_q   <= evict_d;
      removed_q <= removed_d;
      count_q   <= count_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign slot_o          = slot_q;
  assign stale_dropped_o = stale_q;
  assign evicted_o       = evict_q;
  assign removed_o       = removed_q;
  assign entry_count_o   = count_q;

  `VLTC_ASSERT(a_accept_busy, in_valid_i && in_ready_o |=> busy_q, "Accepted beat did not occupy the cells.")
  `VLTC_ASSERT_NEVER(a_count_range, vc_q > CntW'(MAX_ENTRIES), "Entry count exceeds the list length.")
  `VLTC_ASSERT(a_flags_excl, out_valid_o |-> $countones({hit_o, stale_dropped_o, evicted_o, removed_o}) <= 2 && !(hit_o && evicted_o) && !(hit_o && stale_dropped_o), "Result flags conflict.")
  `VLTC_ASSERT(a_stall_hold, busy_q && out_valid_q && !out_ready_i |=> busy_q && $stable(vc_q), "Beat left the cells while the result register was full.")

endmodule

### hw/rtl/vltc_cell.sv
// ----------------------------------------------------------------------------
// Versioned LRU tag cache cell
// One position of the recency list: slot id, key and version, with its
// match flags and its link in the first-match chain.
// ----------------------------------------------------------------------------
module vltc_cell #(
  parameter int unsigned Index      = 0,
  parameter int unsigned NumEntries = vltc_pkg::MaxEntriesDefault,
  parameter int unsigned IdW        = 4,
  parameter int unsigned KeyW       = 32,
  parameter int unsigned CntW       = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  vltc_pkg::cell_ctl_t       ctl_i,
  input  logic [CntW-1:0]           vc_i,
  input  logic [KeyW-1:0]           cmp_key_i,
  input  logic [vltc_pkg::VerW-1:0] cmp_ver_i,
  input  logic                      carry_i,
  output logic                      carry_o,
  input  logic [IdW-1:0]            prev_id_i,
  input  logic [KeyW-1:0]           prev_key_i,
  input  logic [vltc_pkg::VerW-1:0] prev_ver_i,
  input  logic [IdW-1:0]            next_id_i,
  input  logic [KeyW-1:0]           next_key_i,
  input  logic [vltc_pkg::VerW-1:0] next_ver_i,
  input  logic [IdW-1:0]            front_id_i,
  output logic [IdW-1:0]            sel_id_o,
  output logic [IdW-1:0]            id_o,
  output logic [KeyW-1:0]           key_o,
  output logic [vltc_pkg::VerW-1:0] ver_o,
  output logic                      key_match_o,
  output logic                      hit_o
);

  localparam logic IsLast = (Index == NumEntries - 1);

  logic [IdW-1:0]            id_q, id_d;
  logic [KeyW-1:0]           key_q, key_d;
  logic [vltc_pkg::VerW-1:0] ver_q, ver_d;
  logic                      kmatch_q, kmatch_d;
  logic                      vmatch_q, vmatch_d;
  logic                      valid, at_vc, below_tail, at_tail;
  logic                      km, mark, sel;

  always_comb begin
    valid      = CntW'(Index) < vc_i;
    at_vc      = CntW'(Index) == vc_i;
    below_tail = CntW'(Index + 1) < vc_i;
    at_tail    = CntW'(Index + 1) == vc_i;
    km         = valid & kmatch_q;
    if (ctl_i.lookup) begin
      mark = km | at_vc | IsLast;
    end else if (ctl_i.inval) begin
      mark = km;
    end else begin
      mark = 1'b0;
    end
    sel = mark & ~carry_i;
  end

  assign carry_o     = carry_i | mark;
  assign sel_id_o    = sel ? id_q : '0;
  assign id_o        = id_q;
  assign key_o       = key_q;
  assign ver_o       = ver_q;
  assign key_match_o = km;
  assign hit_o       = km & vmatch_q;

  always_comb begin
    id_d     = id_q;
    key_d    = key_q;
    ver_d    = ver_q;
    kmatch_d = kmatch_q;
    vmatch_d = vmatch_q;
    if (ctl_i.load) begin
      kmatch_d = key_q == cmp_key_i;
      vmatch_d = ver_q == cmp_ver_i;
    end
    if (ctl_i.upd) begin
      if (ctl_i.lookup && !carry_i) begin
        id_d  = prev_id_i;
        key_d = prev_key_i;
        ver_d = prev_ver_i;
      end else if (ctl_i.inval && (carry_i || mark)) begin
        if (at_tail) begin
          id_d = front_id_i;
        end else if (below_tail) begin
          id_d  = next_id_i;
          key_d = next_key_i;
          ver_d = next_ver_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q <= IdW'(Index);
    end else begin
      id_q <= id_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    ver_q    <= ver_d;
    kmatch_q <= kmatch_d;
    vmatch_q <= vmatch_d;
  end

endmodule

### tb/sv/versioned_lru_tag_cache_core_tb.sv
// ----------------------------------------------------------------------------
// Versioned LRU tag cache core testbench
// Drives lookup, invalidate, clear and unused operation beats through the
// valid/ready input channel while a model of the recency list predicts each
// result beat that no directed row fixes. Directed rows cover an empty list,
// hits, stale versions, a full list and eviction. Random phases then vary
// sender and receiver idling and include one long receiver hold-off.
`timescale 1ns / 100ps

module versioned_lru_tag_cache_core_tb;
  import vltc_pkg::*;

  localparam int unsigned Depth = MaxEntriesDefault;
  localparam logic [OpW-1:0] OpReserved = 2'd3;
  localparam int unsigned KeyPoolSize = 24;

  typedef struct packed {
    logic              hit;
    logic [SlotW-1:0]  slot;
    logic              stale_dropped;
    logic              evicted;
    logic              removed;
    logic [CountW-1:0] entry_count;
  } cache_result_t;

  typedef struct packed {
    logic [OpW-1:0]     op;
    logic [KeyTagW-1:0] key;
    logic [VerW-1:0]    ver;
    logic [4:0]         reps;
    logic               has_want;
    cache_result_t      want;
  } stim_row_t;

  localparam cache_result_t IdleResult = '0;

  localparam stim_row_t DirectedRows [15] = '{
    '{OP_CLEAR,   32'h0000_0000, 48'h0000_0000_0000, 5'd1,  1'b1, IdleResult},
    '{OP_INVAL,   32'h0000_1234, 48'h0000_0000_0000, 5'd1,  1'b1, IdleResult},
    '{OP_LOOKUP,  32'h0000_0000, 48'h0000_0000_0000, 5'd1,  1'b1,
      '{1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 5'd1}},
    '{OP_LOOKUP,  32'h0000_0000, 48'h0000_0000_0000, 5'd1,  1'b1,
      '{1'b1, 4'd0, 1'b0, 1'b0, 1'b0, 5'd1}},
    '{OP_LOOKUP,  32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 5'd1,  1'b1,
      '{1'b0, 4'd1, 1'b0, 1'b0, 1'b0, 5'd2}},
    '{OP_LOOKUP,  32'h0000_0000, 48'h0000_0000_0001, 5'd1,  1'b0, IdleResult},
    '{OP_LOOKUP,  32'h8000_0000, 48'h5555_5555_5555, 5'd14, 1'b0, IdleResult},
    '{OP_LOOKUP,  32'h7FFF_FFFF, 48'hAAAA_AAAA_AAAA, 5'd1,  1'b0, IdleResult},
    '{OP_LOOKUP,  32'h8000_0005, 48'h5555_5555_555A, 5'd1,  1'b0, IdleResult},
    '{OP_LOOKUP,  32'h8000_0007, 48'h0000_0000_0000, 5'd1,  1'b0, IdleResult},
    '{OP_INVAL,   32'h8000_0003, 48'h0000_0000_0000, 5'd1,  1'b0, IdleResult},
    '{OpReserved, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 5'd1,  1'b0, IdleResult},
    '{OP_LOOKUP,  32'h7FFF_FFFF, 48'hAAAA_AAAA_AAAA, 5'd1,  1'b0, IdleResult},
    '{OP_CLEAR,   32'h0000_0000, 48'h0000_0000_0000, 5'd1,  1'b1, IdleResult},
    '{OP_LOOKUP,  32'h0000_0000, 48'h0000_0000_0001, 5'd1,  1'b0, IdleResult}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [OpW-1:0]     operation_i;
  logic [KeyTagW-1:0] key_tag_i;
  logic [VerW-1:0]    version_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               hit_o;
  logic [SlotW-1:0]   slot_o;
  logic               stale_dropped_o;
  logic               evicted_o;
  logic               removed_o;
  logic [CountW-1:0]  entry_count_o;

  logic [KeyTagW-1:0] line_key [Depth];
  logic [VerW-1:0]    line_ver [Depth];
  logic [SlotW-1:0]   recency  [Depth];
  int                 line_count;

  cache_result_t      pending_results [$];
  logic [KeyTagW-1:0] key_pool [KeyPoolSize];
  int                 src_idle_pct;
  int                 sink_stall_pct;
  int                 sink_hold_cycles;
  int                 fail_count;

  versioned_lru_tag_cache_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .key_tag_i      (key_tag_i),
    .version_i      (version_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hit_o          (hit_o),
    .slot_o         (slot_o),
    .stale_dropped_o(stale_dropped_o),
    .evicted_o      (evicted_o),
    .removed_o      (removed_o),
    .entry_count_o  (entry_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  function automatic void reset_cache_model();
    for (int i = 0; i < Depth; i++) begin
      line_key[i] = '0;
      line_ver[i] = '0;
      recency[i]  = SlotW'(i);
    end
    line_count = 0;
  endfunction

  // The freed slot id goes to the first free position behind the live list.
  function automatic void drop_position(int pos);
    logic [SlotW-1:0] id;
    id = recency[pos];
    for (int i = pos; i + 1 < line_count; i++) recency[i] = recency[i + 1];
    recency[line_count - 1] = id;
    line_count--;
  endfunction

  function automatic void move_to_front(int pos);
    logic [SlotW-1:0] id;
    id = recency[pos];
    for (int i = pos; i > 0; i--) recency[i] = recency[i - 1];
    recency[0] = id;
  endfunction

  function automatic cache_result_t apply_request(logic [OpW-1:0] op,
                                                  logic [KeyTagW-1:0] key,
                                                  logic [VerW-1:0] ver);
    cache_result_t res;
    int            match_pos;
    int            pos;
    res = '0;
    match_pos = -1;
    if (op == OP_LOOKUP) begin
      for (int i = 0; i < line_count; i++) begin
        if (match_pos < 0 && line_key[recency[i]] == key && line_ver[recency[i]] == ver)
          match_pos = i;
      end
      if (match_pos >= 0) begin
        move_to_front(match_pos);
        res.hit = 1'b1;
      end else begin
        for (int i = 0; i < line_count; i++) begin
          if (match_pos < 0 && line_key[recency[i]] == key) match_pos = i;
        end
        if (match_pos >= 0) begin
          drop_position(match_pos);
          res.stale_dropped = 1'b1;
        end
        if (line_count >= Depth) begin
          move_to_front(Depth - 1);
          res.evicted = 1'b1;
        end else begin
          move_to_front(line_count);
          line_count++;
        end
        line_key[recency[0]] = key;
        line_ver[recency[0]] = ver;
      end
      res.slot = recency[0];
    end else if (op == OP_INVAL) begin
      pos = 0;
      while (pos < line_count) begin
        if (line_key[recency[pos]] == key) begin
          drop_position(pos);
          res.removed = 1'b1;
        end else begin
          pos++;
        end
      end
    end else if (op == OP_CLEAR) begin
      line_count = 0;
    end
    res.entry_count = CountW'(line_count);
    return res;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_request(input logic [OpW-1:0] op, input logic [KeyTagW-1:0] key,
                              input logic [VerW-1:0] ver, input logic has_want,
                              input cache_result_t want);
    cache_result_t predicted;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    operation_i = op;
    key_tag_i   = key;
    version_i   = ver;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = apply_request(op, key, ver);
    pending_results.push_back(has_want ? want : predicted);
    @(negedge clk_i);
  endtask

  task automatic wait_results_drained();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic run_random(int count, int src_pct, int sink_pct);
    int                 roll;
    logic [OpW-1:0]     op;
    logic [KeyTagW-1:0] key;
    logic [VerW-1:0]    ver;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    for (int i = 0; i < KeyPoolSize; i++) key_pool[i] = $urandom;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 85) op = OP_LOOKUP;
      else if (roll < 95) op = OP_INVAL;
      else if (roll < 97) op = OP_CLEAR;
      else op = OpReserved;
      if ($urandom_range(0, 9) == 0) key = $urandom;
      else key = key_pool[$urandom_range(0, KeyPoolSize - 1)];
      if ($urandom_range(0, 7) == 0) ver = {16'($urandom), 32'($urandom)};
      else ver = VerW'($urandom_range(0, 2));
      send_request(op, key, ver, 1'b0, IdleResult);
    end
  endtask

  task automatic check_field(string name, logic [VerW-1:0] want, logic [VerW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold_cycles > 0) begin
        out_ready_i = 1'b0;
        sink_hold_cycles--;
      end else begin
        out_ready_i = ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    cache_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no request outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("hit", want.hit, hit_o);
        check_field("slot", want.slot, slot_o);
        check_field("stale_dropped", want.stale_dropped, stale_dropped_o);
        check_field("evicted", want.evicted, evicted_o);
        check_field("removed", want.removed, removed_o);
        check_field("entry_count", want.entry_count, entry_count_o);
      end
    end
  end

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    operation_i      = OP_LOOKUP;
    key_tag_i        = '0;
    version_i        = '0;
    src_idle_pct     = 0;
    sink_stall_pct   = 0;
    sink_hold_cycles = 0;
    fail_count       = 0;
    reset_cache_model();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (DirectedRows[r]) begin
      for (int i = 0; i < DirectedRows[r].reps; i++) begin
        send_request(DirectedRows[r].op, DirectedRows[r].key + KeyTagW'(i),
                     DirectedRows[r].ver + VerW'(i), DirectedRows[r].has_want,
                     DirectedRows[r].want);
      end
    end
    wait_results_drained();

    run_random(120, 0, 0);
    wait_results_drained();
    run_random(120, 84, 0);
    wait_results_drained();
    run_random(120, 0, 84);
    wait_results_drained();

    // The receiver holds off while beats keep coming, so the core backs up.
    sink_hold_cycles = 150;
    run_random(20, 0, 0);
    wait_results_drained();

    run_random(120, 6, 6);
    in_valid_i = 1'b0;
    wait_results_drained();
    repeat (10) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
